// ===== design/ucdp_pkg.sv =====
// Shared types and constants for the USB configuration descriptor parser.
// No dependencies; used by every module.
package ucdp_pkg;

    localparam int MAX_ENDPOINT_SLOTS_DEF = 32;

    // Descriptor types and lengths that produce records
    localparam logic [7:0] DESC_TYPE_IFACE = 8'd4;
    localparam logic [7:0] DESC_TYPE_ENDP  = 8'd5;
    localparam logic [7:0] DESC_LEN_IFACE  = 8'd9;
    localparam logic [7:0] DESC_LEN_ENDP   = 8'd7;

    // Highest byte position whose value is captured
    localparam logic [7:0] CAP_LAST_POS = 8'd8;
    localparam int         CAP_DEPTH    = 7;

    localparam logic [7:0] ADDR_DIR_MASK = 8'h80;
    localparam logic [7:0] ADDR_NUM_MASK = 8'h0F;
    localparam logic [6:0] LIMIT_MAX     = 7'd127;

    typedef enum logic [1:0] {
        REC_IFACE = 2'd0,
        REC_ENDP  = 2'd1,
        REC_BAD   = 2'd2
    } t_rec_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        t_rec_kind   record_kind;
        logic [7:0]  interface_number;
        logic [7:0]  interface_endpoints;
        logic [7:0]  class_code;
        logic [7:0]  subclass_code;
        logic [7:0]  protocol_code;
        logic [5:0]  endpoint_slot;
        logic [7:0]  endpoint_address;
        logic [1:0]  endpoint_kind;
        logic [10:0] max_packet;
        logic [2:0]  packets_per_interval;
        logic [7:0]  poll_interval;
    } t_record;

endpackage

// ===== design/ucdp_ifs.sv =====
// Valid/ready channel interfaces for descriptor words in and records out.
// Depends on nothing; payload fields follow the block's item layout.
interface ucdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface ucdp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [7:0]  interface_number;
    logic [7:0]  interface_endpoints;
    logic [7:0]  class_code;
    logic [7:0]  subclass_code;
    logic [7:0]  protocol_code;
    logic [5:0]  endpoint_slot;
    logic [7:0]  endpoint_address;
    logic [1:0]  endpoint_kind;
    logic [10:0] max_packet;
    logic [2:0]  packets_per_interval;
    logic [7:0]  poll_interval;

    modport source (
        output valid, record_kind, interface_number, interface_endpoints, class_code,
               subclass_code, protocol_code, endpoint_slot, endpoint_address,
               endpoint_kind, max_packet, packets_per_interval, poll_interval,
        input  ready
    );
    modport sink (
        input  valid, record_kind, interface_number, interface_endpoints, class_code,
               subclass_code, protocol_code, endpoint_slot, endpoint_address,
               endpoint_kind, max_packet, packets_per_interval, poll_interval,
        output ready
    );
endinterface

// ===== design/ucdp_in_stage.sv =====
// Input register for descriptor words.
// Depends on ucdp_pkg and ucdp_in_if.
module ucdp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ucdp_in_if.sink            i_in,
    output logic               o_valid,
    output ucdp_pkg::t_item    o_item,
    input  logic               i_take
);

    logic            r_valid;
    ucdp_pkg::t_item r_item;

    // Take a new word when empty or when the held word leaves this cycle
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte  <= i_in.data_byte;
            r_item.first_byte <= i_in.first_byte;
            r_item.last_byte  <= i_in.last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/ucdp_parser.sv =====
// Descriptor parsing state, record build and the result register.
// Depends on ucdp_pkg and ucdp_rec_if.
module ucdp_parser #(
    parameter int MAX_ENDPOINT_SLOTS = ucdp_pkg::MAX_ENDPOINT_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ucdp_pkg::t_item    i_item,
    output logic               o_take,
    ucdp_rec_if.source         o_rec
);

    localparam logic [6:0] SlotCap = 7'(MAX_ENDPOINT_SLOTS);

    logic [7:0]   r_pos, n_pos;
    logic [7:0]   r_len, n_len;
    logic [7:0]   r_type, n_type;
    logic [7:0]   r_cap [ucdp_pkg::CAP_DEPTH];
    logic [7:0]   n_cap [ucdp_pkg::CAP_DEPTH];
    logic [255:0] r_seen, n_seen;
    logic [6:0]   r_limit, n_limit;
    logic [6:0]   r_slot, n_slot;
    logic         r_halted, n_halted;

    logic              r_out_valid;
    ucdp_pkg::t_record r_rec, n_rec;
    logic              rec_hit;

    logic [7:0]   eff_pos;
    logic [6:0]   eff_limit;
    logic [6:0]   eff_slot;
    logic [255:0] eff_seen;
    logic         eff_halted;
    logic [2:0]   cap_idx;
    logic [8:0]   limit_sum;
    logic [7:0]   b;

    assign o_take = i_valid && (!r_out_valid || o_rec.ready);
    assign b      = i_item.data_byte;

    always_comb begin
        // A first word starts from the cleared set state
        eff_pos    = i_item.first_byte ? 8'd0 : r_pos;
        eff_limit  = i_item.first_byte ? 7'd1 : r_limit;
        eff_slot   = i_item.first_byte ? 7'd1 : r_slot;
        eff_seen   = i_item.first_byte ? '0 : r_seen;
        eff_halted = i_item.first_byte ? 1'b0 : r_halted;

        n_pos    = eff_pos;
        n_len    = i_item.first_byte ? 8'd0 : r_len;
        n_type   = i_item.first_byte ? 8'd0 : r_type;
        n_cap    = r_cap;
        n_seen   = eff_seen;
        n_limit  = eff_limit;
        n_slot   = eff_slot;
        n_halted = eff_halted;
        n_rec    = '0;
        rec_hit  = 1'b0;
        cap_idx  = 3'(eff_pos - 8'd2);
        limit_sum = '0;

        if (!eff_halted) begin
            if (eff_pos == 8'd0 && b == 8'd0) begin
                n_halted          = 1'b1;
                n_rec.record_kind = ucdp_pkg::REC_BAD;
                rec_hit           = 1'b1;
            end else begin
                if (eff_pos == 8'd0) begin
                    n_len  = b;
                    n_type = 8'd0;
                    n_pos  = 8'd1;
                end else begin
                    if (eff_pos == 8'd1) begin
                        n_type = b;
                    end else if (eff_pos <= ucdp_pkg::CAP_LAST_POS) begin
                        n_cap[cap_idx] = b;
                    end
                    n_pos = eff_pos + 8'd1;
                end

                if (n_pos >= n_len) begin
                    n_pos = 8'd0;
                    if (i_item.last_byte) begin
                        n_halted = 1'b1;
                    end
                    if (n_len == ucdp_pkg::DESC_LEN_IFACE &&
                        n_type == ucdp_pkg::DESC_TYPE_IFACE) begin
                        if (!eff_seen[n_cap[0]]) begin
                            n_seen[n_cap[0]] = 1'b1;
                            limit_sum = {2'b00, eff_limit} + {1'b0, n_cap[2]};
                            n_limit   = (limit_sum > {2'b00, ucdp_pkg::LIMIT_MAX}) ?
                                        ucdp_pkg::LIMIT_MAX : limit_sum[6:0];
                            n_rec.record_kind         = ucdp_pkg::REC_IFACE;
                            n_rec.interface_number    = n_cap[0];
                            n_rec.interface_endpoints = n_cap[2];
                            n_rec.class_code          = n_cap[3];
                            n_rec.subclass_code       = n_cap[4];
                            n_rec.protocol_code       = n_cap[5];
                            rec_hit                   = 1'b1;
                        end
                    end else if (n_len == ucdp_pkg::DESC_LEN_ENDP &&
                                 n_type == ucdp_pkg::DESC_TYPE_ENDP) begin
                        if (!(eff_slot >= eff_limit || eff_slot >= SlotCap)) begin
                            n_rec.record_kind      = ucdp_pkg::REC_ENDP;
                            n_rec.endpoint_slot    = eff_slot[5:0];
                            n_rec.endpoint_address =
                                n_cap[0] & (ucdp_pkg::ADDR_DIR_MASK | ucdp_pkg::ADDR_NUM_MASK);
                            n_rec.endpoint_kind        = n_cap[1][1:0];
                            n_rec.max_packet           = {n_cap[3][2:0], n_cap[2]};
                            n_rec.packets_per_interval = {1'b0, n_cap[3][4:3]} + 3'd1;
                            n_rec.poll_interval        = n_cap[4];
                            n_slot                     = eff_slot + 7'd1;
                            rec_hit                    = 1'b1;
                        end
                    end
                end else if (i_item.last_byte) begin
                    // Set ended inside a descriptor
                    n_halted          = 1'b1;
                    n_rec.record_kind = ucdp_pkg::REC_BAD;
                    rec_hit           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_len    <= 8'd0;
            r_type   <= 8'd0;
            r_seen   <= '0;
            r_limit  <= 7'd1;
            r_slot   <= 7'd1;
            r_halted <= 1'b0;
        end else if (o_take) begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_type   <= n_type;
            r_seen   <= n_seen;
            r_limit  <= n_limit;
            r_slot   <= n_slot;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cap <= n_cap;
        end
    end

    // Result register: load on a record, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= rec_hit;
        end else if (o_rec.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && rec_hit) begin
            r_rec <= n_rec;
        end
    end

    assign o_rec.valid                = r_out_valid;
    assign o_rec.record_kind          = r_rec.record_kind;
    assign o_rec.interface_number     = r_rec.interface_number;
    assign o_rec.interface_endpoints  = r_rec.interface_endpoints;
    assign o_rec.class_code           = r_rec.class_code;
    assign o_rec.subclass_code        = r_rec.subclass_code;
    assign o_rec.protocol_code        = r_rec.protocol_code;
    assign o_rec.endpoint_slot        = r_rec.endpoint_slot;
    assign o_rec.endpoint_address     = r_rec.endpoint_address;
    assign o_rec.endpoint_kind        = r_rec.endpoint_kind;
    assign o_rec.max_packet           = r_rec.max_packet;
    assign o_rec.packets_per_interval = r_rec.packets_per_interval;
    assign o_rec.poll_interval        = r_rec.poll_interval;

endmodule

// ===== design/usb_config_descriptor_parser.sv =====
// Takes one byte of a configuration descriptor set per cycle and emits at most one
// record per byte: an interface record for each new interface number, an endpoint
// record for each endpoint descriptor that still gets a slot, or a malformed record
// for a zero length byte or a set that ends inside a descriptor. A word is accepted
// every cycle while records are taken; a record is held in the result register after
// its last byte has passed the input register, and the parsing state updates from the
// registered byte. Depends on ucdp_pkg and the channel interfaces in ucdp_ifs.
module usb_config_descriptor_parser #(
    parameter int MAX_ENDPOINT_SLOTS = ucdp_pkg::MAX_ENDPOINT_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucdp_in_if.sink    i_in,
    ucdp_rec_if.source o_rec
);

    logic            stage_valid;
    ucdp_pkg::t_item stage_item;
    logic            stage_take;

    ucdp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (stage_take)
    );

    ucdp_parser #(
        .MAX_ENDPOINT_SLOTS (MAX_ENDPOINT_SLOTS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_item  (stage_item),
        .o_take  (stage_take),
        .o_rec   (o_rec)
    );

endmodule
